>>> rtl/sal_pkg.sv
`timescale 1ns / 1ps

package sal_pkg;

  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;
  localparam int LIMIT_W  = 4;
  localparam int COUNT_W  = 4;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PURGE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0]         REG_LIMIT_ADDR = 2'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 4'd8;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   next_time;
  } sal_res_t;

endpackage

>>> rtl/sal_mem.sv
`timescale 1ns / 1ps

module sal_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/sal_ctrl.sv
`timescale 1ns / 1ps

module sal_ctrl
  import sal_pkg::*;
#(
  parameter int CAPACITY = 8,
  parameter int AW       = 3,
  parameter int CW       = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [TIME_W-1:0]   time_value,
  input  logic [LIMIT_W-1:0]  limit,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [TIME_W-1:0]   mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [TIME_W-1:0]   mem_rdata,
  output sal_res_t            res,
  output logic [COUNT_W-1:0]  count
);

  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_MVWAIT,
    S_PLACE
  } state_t;

  state_t              state_r;
  logic [KIND_W-1:0]   kind_r;
  logic [TIME_W-1:0]   t_r;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       rd_r;
  logic [CW-1:0]       end_r;
  logic [CW-1:0]       shift_r;
  logic                grow_r;
  logic [AW-1:0]       pos_r;
  logic                pend_v_r;
  logic [CW-1:0]       pend_idx_r;
  logic                hit_r;
  logic [CW-1:0]       hit_idx_r;
  logic                gt_r;
  logic [CW-1:0]       gt_idx_r;
  logic [TIME_W-1:0]   gt_val_r;
  logic                mv_v_r;
  logic [AW-1:0]       mv_wa_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TIME_W-1:0]   out_next_r;

  logic          full;
  logic [CW-1:0] first_gt;

  assign full = (LW'(cnt_r) >= LW'(limit)) || (LW'(cnt_r) >= CAP_L);
  // first entry above t_r, or the count when none is
  assign first_gt = gt_r ? gt_idx_r : cnt_r;

  assign busy      = (state_r != S_IDLE);
  assign mem_re    = ((state_r == S_SCAN) && (rd_r < cnt_r)) || (state_r == S_MOVE);
  assign mem_raddr = rd_r[AW-1:0];
  // a shift never reads and writes the same entry in one cycle
  assign mem_we    = mv_v_r || (state_r == S_PLACE);
  assign mem_waddr = (state_r == S_PLACE) ? pos_r : mv_wa_r;
  assign mem_wdata = (state_r == S_PLACE) ? t_r : mem_rdata;

  assign res.valid     = out_valid_r;
  assign res.status    = out_status_r;
  assign res.next_time = out_next_r;
  assign count         = COUNT_W'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      mv_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      gt_r        <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            kind_r   <= kind;
            t_r      <= time_value;
            rd_r     <= '0;
            pend_v_r <= 1'b0;
            hit_r    <= 1'b0;
            gt_r     <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_r < cnt_r) begin
            pend_v_r   <= 1'b1;
            pend_idx_r <= rd_r;
            rd_r       <= rd_r + 1'b1;
          end else begin
            pend_v_r <= 1'b0;
            if (!pend_v_r) begin
              state_r <= S_DECIDE;
            end
          end
          if (pend_v_r) begin
            if (!hit_r && (mem_rdata == t_r)) begin
              hit_r     <= 1'b1;
              hit_idx_r <= pend_idx_r;
            end
            if (!gt_r && (mem_rdata > t_r)) begin
              gt_r     <= 1'b1;
              gt_idx_r <= pend_idx_r;
              gt_val_r <= mem_rdata;
            end
          end
        end
        S_DECIDE: begin
          out_status_r <= ST_OK;
          out_next_r   <= '0;
          state_r      <= S_IDLE;
          case (kind_r)
            KIND_ADD: begin
              if (full) begin
                out_status_r <= ST_FULL;
                out_valid_r  <= 1'b1;
              end else if (hit_r) begin
                out_status_r <= ST_DUPLICATE;
                out_valid_r  <= 1'b1;
              end else begin
                cnt_r  <= cnt_r + 1'b1;
                pos_r  <= first_gt[AW-1:0];
                grow_r <= 1'b1;
                if (first_gt == cnt_r) begin
                  state_r <= S_PLACE;
                end else begin
                  rd_r    <= cnt_r - 1'b1;
                  end_r   <= first_gt;
                  state_r <= S_MOVE;
                end
              end
            end
            KIND_REMOVE: begin
              if (!hit_r) begin
                out_status_r <= ST_NOT_FOUND;
                out_valid_r  <= 1'b1;
              end else begin
                cnt_r   <= cnt_r - 1'b1;
                grow_r  <= 1'b0;
                shift_r <= CW'(1);
                if (hit_idx_r == cnt_r - 1'b1) begin
                  out_valid_r <= 1'b1;
                end else begin
                  rd_r    <= hit_idx_r + 1'b1;
                  end_r   <= cnt_r - 1'b1;
                  state_r <= S_MOVE;
                end
              end
            end
            KIND_PURGE: begin
              cnt_r   <= cnt_r - first_gt;
              grow_r  <= 1'b0;
              shift_r <= first_gt;
              if ((first_gt == '0) || (first_gt == cnt_r)) begin
                out_valid_r <= 1'b1;
              end else begin
                rd_r    <= first_gt;
                end_r   <= cnt_r - 1'b1;
                state_r <= S_MOVE;
              end
            end
            default: begin
              out_next_r  <= gt_r ? gt_val_r : '0;
              out_valid_r <= 1'b1;
            end
          endcase
        end
        S_MOVE: begin
          // read one entry, write it to its new place in the next cycle
          mv_v_r  <= 1'b1;
          mv_wa_r <= grow_r ? AW'(rd_r + 1'b1) : AW'(rd_r - shift_r);
          if (rd_r == end_r) begin
            state_r <= S_MVWAIT;
          end else begin
            rd_r <= grow_r ? rd_r - 1'b1 : rd_r + 1'b1;
          end
        end
        S_MVWAIT: begin
          mv_v_r <= 1'b0;
          if (grow_r) begin
            state_r <= S_PLACE;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_PLACE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/sorted_alarm_list.sv
`timescale 1ns / 1ps

// Sorted list of distinct 32-bit alarm times held in a CAPACITY-entry RAM.
// Input: raise start with in_kind (add, remove, purge, query) and
// in_time_value; the word is taken on a clock edge where busy is low.
// busy stays high until the result word has been produced.
// Output: out_valid is high for one cycle with out_status, out_next_time
// (query only, else 0) and out_alarm_count. The receiver cannot stall.
// Sequence: a scan reads the held entries in order and a decide state
// follows; it finds matches and the first entry above the time. Where
// entries must move, a shift pass through the RAM's read and write ports
// moves them, one entry per cycle, followed by a drain state; an added time
// is then written in a place state. One item is in work at a time.
// Config: APB register 0 (alarm_limit, 4 bits) at byte address 0; write it
// only while busy is low. pready is always high.
// Reset: synchronous, active low. Count clears to zero and alarm_limit
// returns to 8; RAM contents are left as they are, only counted entries
// are ever read.

module sorted_alarm_list
  import sal_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [TIME_W-1:0]   in_time_value,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [TIME_W-1:0]   out_next_time,
  output logic [COUNT_W-1:0]  out_alarm_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [LIMIT_W-1:0] limit_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [TIME_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [TIME_W-1:0]  mem_rdata;
  sal_res_t           res;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_LIMIT_ADDR) ? 32'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_LIMIT_ADDR)) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  sal_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .kind       (in_kind),
    .time_value (in_time_value),
    .limit      (limit_r),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res        (res),
    .count      (out_alarm_count)
  );

  sal_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (TIME_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid     = res.valid;
  assign out_status    = res.status;
  assign out_next_time = res.next_time;

endmodule

>>> dv/alarm_list_checker.sv
`timescale 1ns / 1ps

module alarm_list_checker
  import sal_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [TIME_W-1:0]   in_time_value,
  input  logic                out_valid,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [TIME_W-1:0]   out_next_time,
  input  logic [COUNT_W-1:0]  out_alarm_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  output int                  fail_count,
  output int                  awaiting
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   next_time;
    logic [COUNT_W-1:0]  alarm_count;
  } alarm_word_t;

  // shadow of the sorted list; only entries below held_n are meaningful
  logic [TIME_W-1:0]  alarms [CAPACITY];
  int                 held_n;
  logic [LIMIT_W-1:0] limit_q;
  alarm_word_t        expected_words [$];
  int                 errors;

  initial begin
    fail_count = 0;
    awaiting   = 0;
    errors     = 0;
    held_n     = 0;
    limit_q    = LIMIT_RESET;
  end

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t mismatch %s: expected %0h, got %0h", $time, what, exp_v, got_v);
    errors++;
  endtask

  function automatic int find_alarm(input logic [TIME_W-1:0] t);
    int i;
    for (i = 0; i < held_n; i++) begin
      if (alarms[i] == t) return i;
    end
    return held_n;
  endfunction

  task automatic predict_alarm_op(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                                  output alarm_word_t w);
    int pos;
    int i;
    int eff_limit;
    int drop;
    w = '0;
    w.status = ST_OK;
    eff_limit = (limit_q > CAPACITY) ? CAPACITY : int'(limit_q);
    case (k)
      KIND_ADD: begin
        // fullness wins over duplicate
        if (held_n >= eff_limit) begin
          w.status = ST_FULL;
        end else if (find_alarm(t) < held_n) begin
          w.status = ST_DUPLICATE;
        end else begin
          pos = 0;
          while (pos < held_n && alarms[pos] < t) pos++;
          for (i = held_n; i > pos; i--) alarms[i] = alarms[i-1];
          alarms[pos] = t;
          held_n++;
        end
      end
      KIND_REMOVE: begin
        pos = find_alarm(t);
        if (pos >= held_n) begin
          w.status = ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < held_n; i++) alarms[i] = alarms[i+1];
          held_n--;
        end
      end
      KIND_PURGE: begin
        drop = 0;
        while (drop < held_n && alarms[drop] <= t) drop++;
        for (i = drop; i < held_n; i++) alarms[i-drop] = alarms[i];
        held_n -= drop;
      end
      default: begin
        // strictly later, so an alarm at zero is never returned
        for (i = 0; i < held_n; i++) begin
          if (alarms[i] > t) begin
            w.next_time = alarms[i];
            break;
          end
        end
      end
    endcase
    w.alarm_count = held_n[COUNT_W-1:0];
  endtask

  always @(posedge clk) begin
    alarm_word_t w;
    if (!rst_n) begin
      held_n  = 0;
      limit_q = LIMIT_RESET;
      expected_words.delete();
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", 32'h0, 32'(out_alarm_count));
        end else begin
          w = expected_words.pop_front();
          if (out_status !== w.status)
            report_mismatch("status", 32'(w.status), 32'(out_status));
          if (out_next_time !== w.next_time)
            report_mismatch("next_time", w.next_time, out_next_time);
          if (out_alarm_count !== w.alarm_count)
            report_mismatch("alarm_count", 32'(w.alarm_count), 32'(out_alarm_count));
        end
      end
      if (start && !busy) begin
        predict_alarm_op(in_kind, in_time_value, w);
        expected_words.insert(expected_words.size(), w);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == REG_LIMIT_ADDR) limit_q = pwdata[LIMIT_W-1:0];
        end else if (paddr == REG_LIMIT_ADDR && prdata !== {{(32-LIMIT_W){1'b0}}, limit_q}) begin
          report_mismatch("alarm_limit readback", 32'(limit_q), prdata);
        end
      end
    end
    fail_count <= errors;
    awaiting   <= expected_words.size();
  end

endmodule

>>> dv/tb_sorted_alarm_list.sv
`timescale 1ns / 1ps

module tb_sorted_alarm_list;
  import sal_pkg::*;

  localparam int CAPACITY        = 8;
  localparam int SETTLE          = 2 * CAPACITY + 8;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int PHASES          = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   in_kind;
  logic [TIME_W-1:0]   in_time_value;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [TIME_W-1:0]   out_next_time;
  logic [COUNT_W-1:0]  out_alarm_count;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [1:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  awaiting;
  int                  cycles = 0;
  logic                idling = 1'b1;
  logic [TIME_W-1:0]   pool_base = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_alarm_list #(.CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_time_value(in_time_value),
    .out_valid(out_valid), .out_status(out_status),
    .out_next_time(out_next_time), .out_alarm_count(out_alarm_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  alarm_list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_time_value(in_time_value),
    .out_valid(out_valid), .out_status(out_status),
    .out_next_time(out_next_time), .out_alarm_count(out_alarm_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .fail_count(fail_count), .awaiting(awaiting)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly times near the phase's base so adds collide and removes hit
  function automatic logic [TIME_W-1:0] pick_time();
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 9))
      0:       t = $urandom;
      1:       t = $urandom_range(0, 1) ? '1 : '0;
      default: t = pool_base + $urandom_range(0, 23);
    endcase
    return t;
  endfunction

  task automatic issue_alarm_op(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t);
    int gap;
    if (idling && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 24);
      start <= 1'b0;
      repeat (gap) begin
        in_kind       <= KIND_W'($urandom_range(0, 3));
        in_time_value <= $urandom;
        @(posedge clk);
      end
    end
    start         <= 1'b1;
    in_kind       <= k;
    in_time_value <= t;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic write_alarm_limit(input logic [LIMIT_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (awaiting != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_LIMIT_ADDR;
    pwdata  <= ($urandom & 32'hFFFF_FFF0) | 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // straight into a read-back setup
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int r;
    int p;
    logic [KIND_W-1:0]  k;
    logic [LIMIT_W-1:0] lim;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_kind       <= KIND_ADD;
    in_time_value <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= REG_LIMIT_ADDR;
    pwdata        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, extremes, zero time, full and duplicate, purge edges
    issue_alarm_op(KIND_QUERY,  32'h0000_0000);
    issue_alarm_op(KIND_REMOVE, 32'h0000_0007);
    issue_alarm_op(KIND_PURGE,  32'hFFFF_FFFF);
    issue_alarm_op(KIND_ADD,    32'h0000_0000);
    issue_alarm_op(KIND_ADD,    32'hFFFF_FFFF);
    issue_alarm_op(KIND_ADD,    32'h8000_0000);
    issue_alarm_op(KIND_ADD,    32'h0000_0000);
    issue_alarm_op(KIND_QUERY,  32'h0000_0000);
    issue_alarm_op(KIND_QUERY,  32'hFFFF_FFFF);
    issue_alarm_op(KIND_QUERY,  32'h7FFF_FFFF);
    issue_alarm_op(KIND_ADD,    32'h0000_0010);
    issue_alarm_op(KIND_ADD,    32'h0000_0020);
    issue_alarm_op(KIND_ADD,    32'h0000_0030);
    issue_alarm_op(KIND_ADD,    32'h0000_0040);
    issue_alarm_op(KIND_ADD,    32'h0000_0050);
    issue_alarm_op(KIND_ADD,    32'h0000_0060);
    issue_alarm_op(KIND_ADD,    32'h0000_0020);
    issue_alarm_op(KIND_REMOVE, 32'h0000_0030);
    issue_alarm_op(KIND_REMOVE, 32'h0000_0031);
    issue_alarm_op(KIND_ADD,    32'h5555_5555);
    issue_alarm_op(KIND_PURGE,  32'h0000_0020);
    issue_alarm_op(KIND_QUERY,  32'hAAAA_AAAA);
    issue_alarm_op(KIND_PURGE,  32'hFFFF_FFFE);
    issue_alarm_op(KIND_REMOVE, 32'hFFFF_FFFF);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       lim = 4'd8;
        1:       lim = 4'd15;
        2:       lim = 4'd2;   // usually below the count left by the last phase
        3:       lim = 4'd0;
        4:       lim = 4'd1;
        5:       lim = 4'd9;
        6:       lim = 4'd5;
        default: lim = LIMIT_W'($urandom_range(0, 15));
      endcase
      write_alarm_limit(lim);
      idling = (p != 1);
      case (p)
        5:       pool_base = '0;
        6:       pool_base = 32'hFFFF_FFF0;
        default: pool_base = $urandom;
      endcase
      repeat (ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 45)      k = KIND_ADD;
        else if (r < 65) k = KIND_REMOVE;
        else if (r < 75) k = KIND_PURGE;
        else             k = KIND_QUERY;
        issue_alarm_op(k, pick_time());
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
